[src/assert_macros.svh]
// Assertion macros shared by the RTL files that check their own logic.
// No dependencies; every macro samples on the rising edge of clk and is
// disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A condition that implies another one at the same edge.
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// A condition that implies another one at the next edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/jts_pkg.sv]
// Shared types and constants of the JSON token scanner.
// No dependencies; imported by the scanner core, the result queue and the top level.
package jts_pkg;

  // Width of the internal line counter; it saturates at all ones.
  localparam int LINE_BITS = 16;

  // Depth of the result queue; a power of two.
  localparam int RES_DEPTH    = 4;
  localparam int RES_PTR_BITS = $clog2(RES_DEPTH);
  localparam int RES_CNT_BITS = $clog2(RES_DEPTH + 1);

  // Result kinds.
  localparam logic [1:0] KIND_ECHO  = 2'd0;
  localparam logic [1:0] KIND_TOKEN = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;
  localparam logic [1:0] KIND_END   = 2'd3;

  // Token codes.
  localparam logic [3:0] TOK_COLON    = 4'd0;
  localparam logic [3:0] TOK_COMMA    = 4'd1;
  localparam logic [3:0] TOK_LBRACE   = 4'd2;
  localparam logic [3:0] TOK_RBRACE   = 4'd3;
  localparam logic [3:0] TOK_LBRACKET = 4'd4;
  localparam logic [3:0] TOK_RBRACKET = 4'd5;
  localparam logic [3:0] TOK_STRING   = 4'd6;
  localparam logic [3:0] TOK_NUMBER   = 4'd7;
  localparam logic [3:0] TOK_TRUE     = 4'd8;
  localparam logic [3:0] TOK_FALSE    = 4'd9;
  localparam logic [3:0] TOK_NULL     = 4'd10;

  // Error codes.
  localparam logic [2:0] ERR_STR_CUT  = 3'd0;
  localparam logic [2:0] ERR_BAD_ESC  = 3'd1;
  localparam logic [2:0] ERR_BAD_NUM  = 3'd2;
  localparam logic [2:0] ERR_BAD_WORD = 3'd3;
  localparam logic [2:0] ERR_UNKNOWN  = 3'd4;

  // Scanner modes.
  localparam logic [3:0] M_START    = 4'd0;
  localparam logic [3:0] M_STR_OPEN = 4'd1;
  localparam logic [3:0] M_STR_BODY = 4'd2;
  localparam logic [3:0] M_STR_ESC  = 4'd3;
  localparam logic [3:0] M_NUM_INT  = 4'd4;
  localparam logic [3:0] M_NUM_DOT  = 4'd5;
  localparam logic [3:0] M_NUM_EXP  = 4'd6;
  localparam logic [3:0] M_NUM_SIGN = 4'd7;
  localparam logic [3:0] M_NUM_FRAC = 4'd8;
  localparam logic [3:0] M_NUM_EXPD = 4'd9;
  localparam logic [3:0] M_WORD     = 4'd10;
  localparam logic [3:0] M_DISCARD  = 4'd11;

  typedef logic [LINE_BITS-1:0] line_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  token_code;
    logic [7:0]  echo_char;
    logic [2:0]  error_code;
    logic [15:0] line_number;
    logic        last;
  } result_t;

  // Results of one scanner step: how many, and up to two of them in order.
  typedef struct packed {
    logic [1:0] count;
    result_t    res0;
    result_t    res1;
  } step_t;

  // Scanner state seen from outside the core.
  typedef struct packed {
    logic [3:0]  mode;
    logic [15:0] line_number;
  } core_stat_t;

endpackage

[src/jts_core.sv]
// Scanner core: mode, line counter and word buffer with the one-step next-state logic.
// Depends on jts_pkg.
module jts_core
  import jts_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       go,
  input  logic [7:0] ch,
  input  logic       eoi,
  output step_t      step,
  output core_stat_t stat
);

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_UP_E   = 8'h45;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LO_B   = 8'h62;
  localparam logic [7:0] CH_LO_E   = 8'h65;
  localparam logic [7:0] CH_LO_F   = 8'h66;
  localparam logic [7:0] CH_LO_N   = 8'h6E;
  localparam logic [7:0] CH_LO_R   = 8'h72;
  localparam logic [7:0] CH_LO_T   = 8'h74;
  localparam logic [7:0] CH_LO_U   = 8'h75;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  localparam logic [39:0] KW_FALSE = "false";
  localparam logic [31:0] KW_TRUE  = "true";
  localparam logic [31:0] KW_NULL  = "null";

  localparam logic [2:0] WORD_MAX = 3'd5;
  localparam line_t      LINE_MAX = {LINE_BITS{1'b1}};
  localparam line_t      LINE_ONE = LINE_BITS'(1);

  logic [3:0] mode, mode_next;
  line_t      line_count;
  logic [7:0] letters [WORD_MAX];
  logic [2:0] word_length, word_length_next;
  logic       word_too_long, word_too_long_next;

  logic        letter_we;
  logic [2:0]  letter_idx;
  logic        line_inc, line_reset;
  logic [32:0] line_wide;
  logic [15:0] line_out;

  logic is_digit, is_alpha, is_esc;
  logic fw_valid;
  logic [3:0] fw_tok;

  // Start-byte handling, used at start and after a number or word ends.
  logic       sc_valid, sc_inc, sc_word;
  logic [3:0] sc_mode;
  result_t    sc_res;

  logic       pre_valid, post_valid, do_start, do_fail;
  logic [2:0] fail_code;
  result_t    pre_res, post_res;

  function automatic result_t mk_res(input logic [1:0] k, input logic [3:0] t,
                                     input logic [7:0] e, input logic [2:0] er,
                                     input logic [15:0] ln);
    result_t r;
    r.kind        = k;
    r.token_code  = t;
    r.echo_char   = e;
    r.error_code  = er;
    r.line_number = ln;
    r.last        = 1'b0;
    return r;
  endfunction

  assign line_wide = 33'(line_count);
  assign line_out  = (line_wide > 33'h0FFFF) ? 16'hFFFF : line_wide[15:0];

  assign is_digit = (ch >= 8'h30) && (ch <= 8'h39);
  assign is_alpha = ((ch >= 8'h61) && (ch <= 8'h7A)) || ((ch >= 8'h41) && (ch <= 8'h5A));
  assign is_esc   = (ch == CH_QUOTE) || (ch == CH_BSLASH) || (ch == CH_SLASH) ||
                    (ch == CH_LO_B) || (ch == CH_LO_U) || (ch == CH_LO_F) ||
                    (ch == CH_LO_N) || (ch == CH_LO_R) || (ch == CH_LO_T);

  // Reserved-word match; only letters below word_length are looked at.
  always_comb begin
    fw_valid = 1'b0;
    fw_tok   = TOK_FALSE;
    if (!word_too_long) begin
      if (word_length == 3'd5 &&
          {letters[0], letters[1], letters[2], letters[3], letters[4]} == KW_FALSE) begin
        fw_valid = 1'b1;
        fw_tok   = TOK_FALSE;
      end else if (word_length == 3'd4 &&
                   {letters[0], letters[1], letters[2], letters[3]} == KW_TRUE) begin
        fw_valid = 1'b1;
        fw_tok   = TOK_TRUE;
      end else if (word_length == 3'd4 &&
                   {letters[0], letters[1], letters[2], letters[3]} == KW_NULL) begin
        fw_valid = 1'b1;
        fw_tok   = TOK_NULL;
      end
    end
  end

  always_comb begin
    sc_valid = 1'b0;
    sc_inc   = 1'b0;
    sc_word  = 1'b0;
    sc_mode  = M_START;
    sc_res   = mk_res(KIND_ECHO, TOK_COLON, 8'h00, ERR_STR_CUT, line_out);
    priority if (ch == CH_SPACE || ch == CH_TAB) begin
      sc_valid = 1'b1;
      sc_res   = mk_res(KIND_ECHO, TOK_COLON, ch, ERR_STR_CUT, line_out);
    end else if (ch == CH_NL) begin
      sc_valid = 1'b1;
      sc_inc   = 1'b1;
      sc_res   = mk_res(KIND_ECHO, TOK_COLON, CH_NL, ERR_STR_CUT, line_out);
    end else if (ch == CH_QUOTE) begin
      sc_mode = M_STR_OPEN;
    end else if (is_digit) begin
      sc_mode = M_NUM_INT;
    end else if (ch == CH_COLON) begin
      sc_valid = 1'b1;
      sc_res   = mk_res(KIND_TOKEN, TOK_COLON, 8'h00, ERR_STR_CUT, line_out);
    end else if (ch == CH_COMMA) begin
      sc_valid = 1'b1;
      sc_res   = mk_res(KIND_TOKEN, TOK_COMMA, 8'h00, ERR_STR_CUT, line_out);
    end else if (ch == CH_LBRACE) begin
      sc_valid = 1'b1;
      sc_res   = mk_res(KIND_TOKEN, TOK_LBRACE, 8'h00, ERR_STR_CUT, line_out);
    end else if (ch == CH_RBRACE) begin
      sc_valid = 1'b1;
      sc_res   = mk_res(KIND_TOKEN, TOK_RBRACE, 8'h00, ERR_STR_CUT, line_out);
    end else if (ch == CH_LBRACK) begin
      sc_valid = 1'b1;
      sc_res   = mk_res(KIND_TOKEN, TOK_LBRACKET, 8'h00, ERR_STR_CUT, line_out);
    end else if (ch == CH_RBRACK) begin
      sc_valid = 1'b1;
      sc_res   = mk_res(KIND_TOKEN, TOK_RBRACKET, 8'h00, ERR_STR_CUT, line_out);
    end else if (is_alpha) begin
      sc_word = 1'b1;
      sc_mode = M_WORD;
    end else begin
      // Unknown character; a newline never gets here, so discard follows.
      sc_valid = 1'b1;
      sc_mode  = M_DISCARD;
      sc_res   = mk_res(KIND_ERROR, TOK_COLON, 8'h00, ERR_UNKNOWN, line_out);
    end
  end

  always_comb begin
    pre_valid          = 1'b0;
    pre_res            = mk_res(KIND_ECHO, TOK_COLON, 8'h00, ERR_STR_CUT, line_out);
    post_valid         = 1'b0;
    post_res           = mk_res(KIND_ECHO, TOK_COLON, 8'h00, ERR_STR_CUT, line_out);
    do_start           = 1'b0;
    do_fail            = 1'b0;
    fail_code          = ERR_STR_CUT;
    mode_next          = mode;
    line_inc           = 1'b0;
    line_reset         = 1'b0;
    letter_we          = 1'b0;
    letter_idx         = 3'd0;
    word_length_next   = word_length;
    word_too_long_next = word_too_long;

    if (eoi) begin
      unique case (mode)
        M_STR_OPEN, M_STR_BODY, M_STR_ESC: begin
          pre_valid = 1'b1;
          pre_res   = mk_res(KIND_ERROR, TOK_COLON, 8'h00, ERR_STR_CUT, line_out);
        end
        M_NUM_INT, M_NUM_FRAC, M_NUM_EXPD: begin
          pre_valid = 1'b1;
          pre_res   = mk_res(KIND_TOKEN, TOK_NUMBER, 8'h00, ERR_STR_CUT, line_out);
        end
        M_NUM_DOT, M_NUM_EXP, M_NUM_SIGN: begin
          pre_valid = 1'b1;
          pre_res   = mk_res(KIND_ERROR, TOK_COLON, 8'h00, ERR_BAD_NUM, line_out);
        end
        M_WORD: begin
          pre_valid = 1'b1;
          pre_res   = fw_valid ? mk_res(KIND_TOKEN, fw_tok, 8'h00, ERR_STR_CUT, line_out)
                               : mk_res(KIND_ERROR, TOK_COLON, 8'h00, ERR_BAD_WORD, line_out);
        end
        default: begin
        end
      endcase
      post_valid = 1'b1;
      post_res   = mk_res(KIND_END, TOK_COLON, 8'h00, ERR_STR_CUT, line_out);
      mode_next  = M_START;
      line_reset = 1'b1;
    end else begin
      unique case (mode)
        M_STR_OPEN, M_STR_BODY: begin
          priority if (ch == CH_BSLASH) begin
            mode_next = M_STR_ESC;
          end else if (ch == CH_QUOTE) begin
            pre_valid = 1'b1;
            pre_res   = mk_res(KIND_TOKEN, TOK_STRING, 8'h00, ERR_STR_CUT, line_out);
            mode_next = M_START;
          end else begin
            mode_next = M_STR_BODY;
          end
        end
        M_STR_ESC: begin
          if (is_esc) begin
            mode_next = M_STR_BODY;
          end else begin
            do_fail   = 1'b1;
            fail_code = ERR_BAD_ESC;
          end
        end
        M_NUM_INT, M_NUM_FRAC: begin
          priority if (is_digit) begin
            mode_next = mode;
          end else if (ch == CH_DOT && mode == M_NUM_INT) begin
            mode_next = M_NUM_DOT;
          end else if (ch == CH_LO_E || ch == CH_UP_E) begin
            mode_next = M_NUM_EXP;
          end else begin
            pre_valid = 1'b1;
            pre_res   = mk_res(KIND_TOKEN, TOK_NUMBER, 8'h00, ERR_STR_CUT, line_out);
            do_start  = 1'b1;
          end
        end
        M_NUM_DOT, M_NUM_SIGN: begin
          if (is_digit) begin
            mode_next = (mode == M_NUM_DOT) ? M_NUM_FRAC : M_NUM_EXPD;
          end else begin
            do_fail   = 1'b1;
            fail_code = ERR_BAD_NUM;
          end
        end
        M_NUM_EXP: begin
          priority if (ch == CH_PLUS || ch == CH_MINUS) begin
            mode_next = M_NUM_SIGN;
          end else if (is_digit) begin
            mode_next = M_NUM_EXPD;
          end else begin
            do_fail   = 1'b1;
            fail_code = ERR_BAD_NUM;
          end
        end
        M_NUM_EXPD: begin
          if (!is_digit) begin
            pre_valid = 1'b1;
            pre_res   = mk_res(KIND_TOKEN, TOK_NUMBER, 8'h00, ERR_STR_CUT, line_out);
            do_start  = 1'b1;
          end
        end
        M_WORD: begin
          priority if (is_alpha) begin
            if (word_length < WORD_MAX) begin
              letter_we        = 1'b1;
              letter_idx       = word_length;
              word_length_next = word_length + 3'd1;
            end else begin
              word_too_long_next = 1'b1;
            end
          end else if (fw_valid) begin
            pre_valid = 1'b1;
            pre_res   = mk_res(KIND_TOKEN, fw_tok, 8'h00, ERR_STR_CUT, line_out);
            do_start  = 1'b1;
          end else begin
            do_fail   = 1'b1;
            fail_code = ERR_BAD_WORD;
          end
        end
        M_DISCARD: begin
          if (ch == CH_NL) begin
            pre_valid = 1'b1;
            pre_res   = mk_res(KIND_ECHO, TOK_COLON, CH_NL, ERR_STR_CUT, line_out);
            line_inc  = 1'b1;
            mode_next = M_START;
          end
        end
        default: begin
          do_start = 1'b1;
        end
      endcase

      if (do_start) begin
        post_valid = sc_valid;
        post_res   = sc_res;
        mode_next  = sc_mode;
        line_inc   = sc_inc;
        if (sc_word) begin
          letter_we          = 1'b1;
          letter_idx         = 3'd0;
          word_length_next   = 3'd1;
          word_too_long_next = 1'b0;
        end
      end

      // An error; a newline that caused it is still echoed and counted.
      if (do_fail) begin
        pre_valid = 1'b1;
        pre_res   = mk_res(KIND_ERROR, TOK_COLON, 8'h00, fail_code, line_out);
        if (ch == CH_NL) begin
          post_valid = 1'b1;
          post_res   = mk_res(KIND_ECHO, TOK_COLON, CH_NL, ERR_STR_CUT, line_out);
          line_inc   = 1'b1;
          mode_next  = M_START;
        end else begin
          mode_next = M_DISCARD;
        end
      end
    end
  end

  // Pack the results of this step in order and flag the final one.
  always_comb begin
    step.count = 2'(pre_valid) + 2'(post_valid);
    step.res0  = pre_valid ? pre_res : post_res;
    step.res1  = post_res;
    step.res0.last = !(pre_valid && post_valid);
    step.res1.last = 1'b1;
    if (!(pre_valid && post_valid)) begin
      step.res1 = '0;
    end
  end

  assign stat.mode        = mode;
  assign stat.line_number = line_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= M_START;
      line_count    <= LINE_ONE;
      word_length   <= 3'd0;
      word_too_long <= 1'b0;
    end else if (go) begin
      mode          <= mode_next;
      word_length   <= word_length_next;
      word_too_long <= word_too_long_next;
      if (line_reset) begin
        line_count <= LINE_ONE;
      end else if (line_inc && line_count != LINE_MAX) begin
        line_count <= line_count + LINE_ONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && letter_we) begin
      letters[letter_idx] <= ch;
    end
  end

endmodule

[src/jts_result_fifo.sv]
// Result queue: takes up to two results per cycle; one goes out per ready cycle.
// Depends on jts_pkg.
module jts_result_fifo
  import jts_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  step_t   step,
  output logic    room,
  output logic    valid,
  input  logic    ready,
  output result_t data
);

  result_t                 entries [RES_DEPTH];
  logic [RES_PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [RES_CNT_BITS-1:0] count;
  logic [1:0]              push_n;
  logic                    pop;

  assign push_n = push ? step.count : 2'd0;
  assign pop    = valid && ready;
  assign valid  = (count != '0);
  assign data   = entries[rd_ptr];
  assign room   = (count <= RES_CNT_BITS'(RES_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + RES_PTR_BITS'(push_n);
      rd_ptr <= rd_ptr + RES_PTR_BITS'(pop);
      count  <= count + RES_CNT_BITS'(push_n) - RES_CNT_BITS'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      entries[wr_ptr] <= step.res0;
    end
    if (push_n == 2'd2) begin
      entries[wr_ptr + RES_PTR_BITS'(1)] <= step.res1;
    end
  end

endmodule

[src/json_token_scanner_unit.sv]
// Top level of the JSON token scanner: input register, scanner core, result queue.
// Depends on jts_pkg, jts_core, jts_result_fifo and assert_macros.svh.
//
//   Channel   Handshake                    Payload
//   item      item_valid / item_ready      ch, end_of_input
//   result    result_valid / result_ready  kind, token_code, echo_char,
//                                          error_code, line_number, last
//
// One request is taken per cycle while item_ready is high; it is held in the input
// register, where the scanner core handles it in a single step, and its zero, one or
// two results are written into the result queue, whose head drives the result port.
// The rate is one request per cycle while the queue has room, set by the core's
// one-step state update; results go out one per cycle while result_ready is high.
// Reset (rst, synchronous, active high) puts the scanner at start on line one and
// empties the queue; no clearing pass is needed.
// A stalled result side fills the queue, which holds back the input register and
// then item_ready; nothing is dropped.
`include "assert_macros.svh"

module json_token_scanner_unit
  import jts_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic [7:0]  ch,
  input  logic        end_of_input,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [1:0]  kind,
  output logic [3:0]  token_code,
  output logic [7:0]  echo_char,
  output logic [2:0]  error_code,
  output logic [15:0] line_number,
  output logic        last
);

  // Input register.
  logic       s_valid;
  logic [7:0] s_ch;
  logic       s_eoi;

  logic       step_go;
  logic       fifo_room;
  step_t      step;
  core_stat_t stat;
  result_t    head;

  // The core steps when the held request's results are sure to fit in the queue.
  assign step_go    = s_valid && fifo_room;
  assign item_ready = !s_valid || step_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (item_ready) begin
      s_valid <= item_valid;
    end
  end

  // The payload needs no reset; it is only used while s_valid is high.
  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      s_ch  <= ch;
      s_eoi <= end_of_input;
    end
  end

  jts_core u_core (
    .clk  (clk),
    .rst  (rst),
    .go   (step_go),
    .ch   (s_ch),
    .eoi  (s_eoi),
    .step (step),
    .stat (stat)
  );

  jts_result_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (step_go),
    .step  (step),
    .room  (fifo_room),
    .valid (result_valid),
    .ready (result_ready),
    .data  (head)
  );

  assign kind        = head.kind;
  assign token_code  = head.token_code;
  assign echo_char   = head.echo_char;
  assign error_code  = head.error_code;
  assign line_number = head.line_number;
  assign last        = head.last;

  // A step never makes more than two results.
  `ASSERT_SAME(a_step_count, step_go, step.count != 2'd3, "scanner step made three results")
  // With two results only the second one is marked last.
  `ASSERT_SAME(a_last_order, step_go && step.count == 2'd2,
               !step.res0.last && step.res1.last, "wrong last flags on a two-result step")
  // Every end of input ends with an end result and a scanner back at start on line one.
  `ASSERT_SAME(a_end_result, step_go && s_eoi,
               step.count != 2'd0 && (step.count == 2'd1 ? step.res0.kind : step.res1.kind)
               == KIND_END, "end of input without an end result")
  `ASSERT_NEXT(a_end_restart, step_go && s_eoi,
               stat.mode == M_START && stat.line_number == 16'd1,
               "scanner not restarted after end of input")

endmodule
